// ----- hw/rtl/line_convex_planes_hit_test_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the line convex planes hit test block
// Concurrent assertion helpers that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_CONVEX_PLANES_HIT_TEST_TOP_MACROS_SVH
`define LINE_CONVEX_PLANES_HIT_TEST_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/lcph_pkg.sv -----
// ----------------------------------------------------------------------------
// Line convex planes hit test package
// Shared widths, codes and controller to datapath signal groups.
// ----------------------------------------------------------------------------
`default_nettype none
package lcph_pkg;
  localparam int ACC_W     = 67;
  localparam int DIVD_W    = ACC_W + 16;
  localparam int DIV_STEPS = DIVD_W;
  localparam int DCW       = 7;
  localparam int PLANE_W   = 128;
  localparam int MAC_LAST  = 6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_PLANE_COUNT = 1'b0;

  typedef struct packed {
    logic       init;
    logic       mac_en;
    logic [2:0] mac_step;
    logic       div_load;
    logic       div_step;
    logic       update;
    logic       set_miss;
  } cmd_t;

  typedef struct packed {
    logic vd_zero;
    logic vn_neg;
  } sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/line_convex_planes_hit_test_top.sv -----
// ----------------------------------------------------------------------------
// Line convex planes hit test
// A load beat writes one clip plane and returns nothing. A query beat tests a
// line against the first plane_count planes (at most MAX_PLANES) and returns
// one hit strobe. Per plane: a table read, dot products on the shared 32 by 32
// multiplier, a check, the bit-serial restoring divider and a bound update; a
// line parallel to a plane skips the divider and may end the query as a miss.
// busy stays high until the result cycle ends; the result cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_convex_planes_hit_test_top_macros.svh"
module line_convex_planes_hit_test_top #(
  parameter int MAX_PLANES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_op,
  input  wire logic [3:0]         in_plane_index,
  input  wire logic signed [31:0] in_normal_x,
  input  wire logic signed [31:0] in_normal_y,
  input  wire logic signed [31:0] in_normal_z,
  input  wire logic signed [31:0] in_plane_offset,
  input  wire logic signed [31:0] in_origin_x,
  input  wire logic signed [31:0] in_origin_y,
  input  wire logic signed [31:0] in_origin_z,
  input  wire logic signed [31:0] in_dir_x,
  input  wire logic signed [31:0] in_dir_y,
  input  wire logic signed [31:0] in_dir_z,
  output logic                    out_valid,
  output logic                    out_hit,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  localparam int AW = MAX_PLANES > 1 ? $clog2(MAX_PLANES) : 1;

  logic            accept, query_go, we;
  logic [4:0]      plane_count_r;
  logic [31:0]     widx;
  logic [AW-1:0]   raddr;
  logic [lcph_pkg::PLANE_W-1:0] rdata;
  lcph_pkg::cmd_t  cmd;
  lcph_pkg::sts_t  sts;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == lcph_pkg::REG_PLANE_COUNT) ? 32'(plane_count_r) : 32'd0;
  assign accept   = start && !busy;
  assign query_go = accept && (in_op == lcph_pkg::OP_QUERY);
  assign widx     = 32'(in_plane_index);
  assign we       = accept && (in_op == lcph_pkg::OP_LOAD) && (widx < 32'(MAX_PLANES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_count_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == lcph_pkg::REG_PLANE_COUNT) begin
      plane_count_r <= pwdata[4:0];
    end
  end

  lcph_ram #(
    .WIDTH(lcph_pkg::PLANE_W),
    .DEPTH(MAX_PLANES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (widx[AW-1:0]),
    .wdata ({in_plane_offset, in_normal_z, in_normal_y, in_normal_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  lcph_ctrl #(
    .MAX_PLANES(MAX_PLANES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .query_go    (query_go),
    .plane_count (plane_count_r),
    .sts         (sts),
    .cmd         (cmd),
    .raddr       (raddr),
    .busy        (busy),
    .done        (out_valid)
  );

  lcph_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .plane    (rdata),
    .origin_x (in_origin_x),
    .origin_y (in_origin_y),
    .origin_z (in_origin_z),
    .dir_x    (in_dir_x),
    .dir_y    (in_dir_y),
    .dir_z    (in_dir_z),
    .sts      (sts),
    .hit      (out_hit)
  );

  `ASSERT_NEXT(a_query_busy, clk, rst_n, query_go, busy, "Query beat did not raise busy.")
  `ASSERT_NEXT(a_load_idle, clk, rst_n, accept && !query_go, !busy, "Load beat raised busy.")
  `ASSERT_NEXT(a_one_strobe, clk, rst_n, out_valid, !out_valid && !busy, "Result held too long.")
  `ASSERT_SAME(a_strobe_busy, clk, rst_n, out_valid, busy, "Result outside a query.")
endmodule
`default_nettype wire

// ----- hw/rtl/lcph_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lcph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/lcph_ctrl.sv -----
// ----------------------------------------------------------------------------
// Line convex planes hit test controller
// Sequences table reads, dot products, division and bound updates per plane.
// ----------------------------------------------------------------------------
`default_nettype none
module lcph_ctrl #(
  parameter int MAX_PLANES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  query_go,
  input  wire logic [4:0]            plane_count,
  input  wire lcph_pkg::sts_t        sts,
  output lcph_pkg::cmd_t             cmd,
  output logic [(MAX_PLANES > 1 ? $clog2(MAX_PLANES) : 1)-1:0] raddr,
  output logic                       busy,
  output logic                       done
);
  localparam int AW = MAX_PLANES > 1 ? $clog2(MAX_PLANES) : 1;
  localparam int CW = $clog2(MAX_PLANES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                state_r, state_nxt;
  logic [CW-1:0]             pidx_r, pidx_nxt;
  logic [2:0]                step_r, step_nxt;
  logic [lcph_pkg::DCW-1:0]  dcnt_r, dcnt_nxt;
  logic [31:0]               cnt32, n32;
  logic                      last;

  assign cnt32 = 32'(plane_count);
  assign n32   = (cnt32 > 32'(MAX_PLANES)) ? 32'(MAX_PLANES) : cnt32;
  assign last  = (32'(pidx_r) + 32'd1) == n32;
  assign raddr = pidx_r[AW-1:0];
  assign busy  = state_r != S_IDLE;
  assign done  = state_r == S_DONE;

  always_comb begin
    state_nxt    = state_r;
    pidx_nxt     = pidx_r;
    step_nxt     = step_r;
    dcnt_nxt     = dcnt_r;
    cmd          = '0;
    cmd.mac_step = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (query_go) begin
          cmd.init  = 1'b1;
          pidx_nxt  = '0;
          state_nxt = (n32 == 32'd0) ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        step_nxt  = '0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        step_nxt   = step_r + 3'd1;
        if (step_r == 3'(lcph_pkg::MAC_LAST)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.vd_zero) begin
          if (sts.vn_neg) begin
            cmd.set_miss = 1'b1;
            state_nxt    = S_DONE;
          end else if (last) begin
            state_nxt = S_DONE;
          end else begin
            pidx_nxt  = pidx_r + CW'(1);
            state_nxt = S_READ;
          end
        end else begin
          cmd.div_load = 1'b1;
          dcnt_nxt     = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + lcph_pkg::DCW'(1);
        if (dcnt_r == lcph_pkg::DCW'(lcph_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        if (last) begin
          state_nxt = S_DONE;
        end else begin
          pidx_nxt  = pidx_r + CW'(1);
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pidx_r  <= '0;
      step_r  <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pidx_r  <= pidx_nxt;
      step_r  <= step_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/lcph_dp.sv -----
// ----------------------------------------------------------------------------
// Line convex planes hit test datapath
// Shared multiplier, dot product accumulators, restoring divider and bounds.
// ----------------------------------------------------------------------------
`default_nettype none
module lcph_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lcph_pkg::cmd_t               cmd,
  input  wire logic [lcph_pkg::PLANE_W-1:0] plane,
  input  wire logic signed [31:0]           origin_x,
  input  wire logic signed [31:0]           origin_y,
  input  wire logic signed [31:0]           origin_z,
  input  wire logic signed [31:0]           dir_x,
  input  wire logic signed [31:0]           dir_y,
  input  wire logic signed [31:0]           dir_z,
  output lcph_pkg::sts_t                    sts,
  output logic                              hit
);
  localparam int AW = lcph_pkg::ACC_W;
  localparam int DW = lcph_pkg::DIVD_W;

  logic signed [31:0] ox_r, oy_r, oz_r, vx_r, vy_r, vz_r;
  logic signed [31:0] nx, ny, nz, pd, ma, mb;
  logic signed [63:0] prod_r;
  logic signed [AW-1:0] vd_r, vn_r, vn_init;
  logic [AW-1:0]      b_r, r_r;
  logic [DW-1:0]      a_r;
  logic [31:0]        q_r, lim, qs, t;
  logic               ovf_r, neg_r, vdneg_r, miss_r;
  logic signed [31:0] near_r, far_r;
  logic [AW:0]        r_sh;
  logic               ge;

  assign nx = plane[31:0];
  assign ny = plane[63:32];
  assign nz = plane[95:64];
  assign pd = plane[127:96];
  assign vn_init = -AW'(signed'({pd, 16'b0}));

  always_comb begin
    unique case (cmd.mac_step)
      3'd0: begin ma = nx; mb = vx_r; end
      3'd1: begin ma = ny; mb = vy_r; end
      3'd2: begin ma = nz; mb = vz_r; end
      3'd3: begin ma = nx; mb = ox_r; end
      3'd4: begin ma = ny; mb = oy_r; end
      3'd5: begin ma = nz; mb = oz_r; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign sts.vd_zero = vd_r == '0;
  assign sts.vn_neg  = vn_r[AW-1];

  assign r_sh = {r_r, a_r[DW-1]};
  assign ge   = r_sh >= {1'b0, b_r};
  assign lim  = neg_r ? 32'h8000_0000 : 32'h7fff_ffff;
  assign qs   = (ovf_r || q_r > lim) ? lim : q_r;
  assign t    = neg_r ? (~qs + 32'd1) : qs;
  assign hit  = !miss_r && (near_r < far_r);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      ox_r <= origin_x; oy_r <= origin_y; oz_r <= origin_z;
      vx_r <= dir_x;    vy_r <= dir_y;    vz_r <= dir_z;
    end
    if (cmd.mac_en) begin
      prod_r <= 64'(ma) * 64'(mb);
      if (cmd.mac_step == 3'd0) begin
        vd_r <= '0;
        vn_r <= vn_init;
      end else if (cmd.mac_step < 3'd4) begin
        vd_r <= vd_r + AW'(prod_r);
      end else begin
        vn_r <= vn_r + AW'(prod_r);
      end
    end
    if (cmd.div_load) begin
      neg_r   <= vn_r[AW-1] ^ vd_r[AW-1];
      vdneg_r <= vd_r[AW-1];
      b_r     <= vd_r[AW-1] ? AW'(-vd_r) : AW'(vd_r);
      a_r     <= {(vn_r[AW-1] ? AW'(-vn_r) : AW'(vn_r)), 16'b0};
      r_r     <= '0;
      q_r     <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.div_step) begin
      r_r   <= ge ? AW'(r_sh - {1'b0, b_r}) : r_sh[AW-1:0];
      a_r   <= {a_r[DW-2:0], 1'b0};
      ovf_r <= ovf_r | q_r[31];
      q_r   <= {q_r[30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= 32'sh8000_0000;
      far_r  <= 32'sh7fff_ffff;
      miss_r <= 1'b0;
    end else if (cmd.init) begin
      near_r <= 32'sh8000_0000;
      far_r  <= 32'sh7fff_ffff;
      miss_r <= 1'b0;
    end else begin
      if (cmd.set_miss) begin
        miss_r <= 1'b1;
      end
      if (cmd.update) begin
        if (vdneg_r) begin
          if (signed'(t) > near_r) begin
            near_r <= signed'(t);
          end
        end else if (signed'(t) < far_r) begin
          far_r <= signed'(t);
        end
      end
    end
  end
endmodule
`default_nettype wire
